### rtl/dmh_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dmh_pkg: shared constants and types for the double modulus string hash
// Hash base, the two moduli, field widths and stream packing of the block.
// ----------------------------------------------------------------------------
package dmh_pkg;

   // Hash arithmetic
   localparam int unsigned HASH_BASE = 131;
   localparam int unsigned MOD_A     = 532919237;
   localparam int unsigned MOD_B     = 9587;
   localparam int unsigned A_W       = 29;   // hash_a width, MOD_A < 2**A_W
   localparam int unsigned B_W       = 14;   // hash_b width, MOD_B < 2**B_W

   // Item fields
   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned IDX_W     = 12;
   localparam int unsigned MAX_LEN_DEF = 4096;

   // Stream packing
   localparam int unsigned REQ_DATA_W = ((BYTE_W + 2 * IDX_W + 7) / 8) * 8;
   localparam int unsigned REQ_USER_W = 2;
   localparam int unsigned RSP_DATA_W = ((A_W + B_W + 7) / 8) * 8;
   localparam int unsigned RSP_USER_W = 1;

   // req_tuser bit positions
   localparam int unsigned REQ_USER_ACTION = 0;
   localparam int unsigned REQ_USER_FIRST  = 1;

   // Action codes
   localparam logic ACT_APPEND = 1'b0;
   localparam logic ACT_QUERY  = 1'b1;

   // One stored word: both hashes of one position
   typedef struct packed {
      logic [B_W-1:0] b;
      logic [A_W-1:0] a;
   } hash_pair_type;

endpackage
`default_nettype wire

### rtl/double_mod_prefix_string_hash.sv
`default_nettype none
// ----------------------------------------------------------------------------
// double_mod_prefix_string_hash: prefix and substring hash, base 131
// Builds a string one byte per append item and answers substring queries
// with hashes modulo 532919237 and 9587.
// ----------------------------------------------------------------------------
// Usage: one item is worked on at a time; one result item per input item.
// Each item runs from decode to the result state before req_tready rises
// again: an append through the append states, a query through the query
// states and a refused item (full store, bad indices) through neither.
// They follow the four-stage constant-modulus reduction pipeline that every
// hash update and every product passes through, and the registered reads of
// the prefix and power memories, twice in sequence on the prefix port for a
// query. A finished result waits in an output register, so the next item is
// taken while it is still unread. The memories need no clearing after reset:
// a valid query only uses positions written since the last restart.
// ----------------------------------------------------------------------------
module double_mod_prefix_string_hash #(
   parameter int unsigned MAX_LEN = dmh_pkg::MAX_LEN_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // req_tdata: char_byte[7:0], left_index[19:8], right_index[31:20]
   input  wire logic [dmh_pkg::REQ_DATA_W-1:0]    req_tdata,
   // req_tuser: action[0], first[1]
   input  wire logic [dmh_pkg::REQ_USER_W-1:0]    req_tuser,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // rsp_tdata: hash_a[28:0], hash_b[42:29], zero fill[47:43]
   output logic [dmh_pkg::RSP_DATA_W-1:0]         rsp_tdata,
   // rsp_tuser: error[0], set for a refused query or append
   output logic [dmh_pkg::RSP_USER_W-1:0]         rsp_tuser,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready
);
   import dmh_pkg::*;

   localparam int unsigned ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int unsigned LEN_W  = $clog2(MAX_LEN + 1);
   localparam int unsigned WIDE_W = (LEN_W > IDX_W) ? LEN_W : IDX_W;
   localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(MAX_LEN);
   localparam logic [A_W-1:0]   MA = A_W'(MOD_A);
   localparam logic [B_W-1:0]   MB = B_W'(MOD_B);

   // Sequencer states
   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_DECODE = 4'd1;
   localparam logic [3:0] S_AP1    = 4'd2;
   localparam logic [3:0] S_AP2    = 4'd3;
   localparam logic [3:0] S_AP3    = 4'd4;
   localparam logic [3:0] S_AP4    = 4'd5;
   localparam logic [3:0] S_AP5    = 4'd6;
   localparam logic [3:0] S_Q1     = 4'd7;
   localparam logic [3:0] S_Q2     = 4'd8;
   localparam logic [3:0] S_Q3     = 4'd9;
   localparam logic [3:0] S_Q4     = 4'd10;
   localparam logic [3:0] S_Q5     = 4'd11;
   localparam logic [3:0] S_Q6     = 4'd12;
   localparam logic [3:0] S_RESULT = 4'd13;

   // Control and running state
   logic [3:0]       state_ff, state_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [A_W-1:0]   h_a_ff, h_a_in;
   logic [B_W-1:0]   h_b_ff, h_b_in;
   logic [A_W-1:0]   pow_a_ff, pow_a_in;
   logic [B_W-1:0]   pow_b_ff, pow_b_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // Latched item
   logic             act_ff;
   logic [BYTE_W-1:0] byte_ff;
   logic             first_ff;
   logic [IDX_W-1:0] l_ff;
   logic [IDX_W-1:0] r_ff;

   // Query datapath
   logic [2*A_W-1:0] prod_a_ff, prod_a_in;
   logic [2*B_W-1:0] prod_b_ff, prod_b_in;
   logic [A_W-1:0]   hi_a_ff, hi_a_in;
   logic [B_W-1:0]   hi_b_ff, hi_b_in;

   // Result staging and output register
   logic [A_W-1:0]   res_a_ff, res_a_in;
   logic [B_W-1:0]   res_b_ff, res_b_in;
   logic             res_err_ff, res_err_in;
   logic [A_W-1:0]   rsp_a_ff, rsp_a_in;
   logic [B_W-1:0]   rsp_b_ff, rsp_b_in;
   logic             rsp_err_ff, rsp_err_in;

   // Memories
   hash_pair_type    prefix_mem [MAX_LEN];
   hash_pair_type    power_mem  [MAX_LEN];
   hash_pair_type    prefix_rd_ff;
   hash_pair_type    power_rd_ff;
   logic [ADDR_W-1:0] pre_raddr;
   logic [ADDR_W-1:0] pow_raddr;
   logic [ADDR_W-1:0] pos_addr;
   logic             mem_we;

   // Reduction units
   logic [2*A_W-1:0] red_x_a;
   logic [2*B_W-1:0] red_x_b;
   logic [A_W-1:0]   red_r_a;
   logic [B_W-1:0]   red_r_b;

   logic [WIDE_W-1:0] l_wide, r_wide, len_wide, lm1_wide, span_wide;
   logic             q_bad;
   logic             req_fire;
   logic [A_W+BYTE_W-1:0] hx_a;
   logic [B_W+BYTE_W-1:0] hx_b;
   logic [A_W-1:0]   h_eff_a;
   logic [B_W-1:0]   h_eff_b;
   logic [A_W:0]     diff_a;
   logic [B_W:0]     diff_b;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   // Index arithmetic and query check
   assign l_wide    = WIDE_W'(l_ff);
   assign r_wide    = WIDE_W'(r_ff);
   assign len_wide  = WIDE_W'(len_ff);
   assign lm1_wide  = l_wide - WIDE_W'(1);
   assign span_wide = r_wide - l_wide;
   assign q_bad     = (l_ff > r_ff) || (r_wide >= len_wide);

   assign pre_raddr = (state_ff == S_Q1) ? r_wide[ADDR_W-1:0] : lm1_wide[ADDR_W-1:0];
   assign pow_raddr = span_wide[ADDR_W-1:0];
   assign pos_addr  = len_ff[ADDR_W-1:0];

   // Hash step operands: h*131 + byte, restarted by first
   assign h_eff_a = first_ff ? '0 : h_a_ff;
   assign h_eff_b = first_ff ? '0 : h_b_ff;
   assign hx_a = (A_W + BYTE_W)'(h_eff_a) * (A_W + BYTE_W)'(HASH_BASE)
               + (A_W + BYTE_W)'(byte_ff);
   assign hx_b = (B_W + BYTE_W)'(h_eff_b) * (B_W + BYTE_W)'(HASH_BASE)
               + (B_W + BYTE_W)'(byte_ff);

   // Reducer operand select
   always_comb begin
      red_x_a = '0;
      red_x_b = '0;
      unique case (state_ff)
         S_DECODE: begin
            red_x_a = (2 * A_W)'(hx_a);
            red_x_b = (2 * B_W)'(hx_b);
         end
         S_AP1: begin
            red_x_a = (2 * A_W)'(pow_a_ff) * (2 * A_W)'(HASH_BASE);
            red_x_b = (2 * B_W)'(pow_b_ff) * (2 * B_W)'(HASH_BASE);
         end
         S_Q2: begin
            red_x_a = prod_a_ff;
            red_x_b = prod_b_ff;
         end
         default: begin
            red_x_a = '0;
            red_x_b = '0;
         end
      endcase
   end

   dmh_reduce #(
      .MODULUS (MOD_A),
      .MOD_W   (A_W)
   ) u_red_a (
      .clock (clock),
      .x     (red_x_a),
      .r     (red_r_a)
   );

   dmh_reduce #(
      .MODULUS (MOD_B),
      .MOD_W   (B_W)
   ) u_red_b (
      .clock (clock),
      .x     (red_x_b),
      .r     (red_r_b)
   );

   // Substring hash: pre[r] - lo, wrapped into range
   assign diff_a = {1'b0, hi_a_ff} - {1'b0, red_r_a};
   assign diff_b = {1'b0, hi_b_ff} - {1'b0, red_r_b};

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      h_a_in       = h_a_ff;
      h_b_in       = h_b_ff;
      pow_a_in     = pow_a_ff;
      pow_b_in     = pow_b_ff;
      prod_a_in    = prod_a_ff;
      prod_b_in    = prod_b_ff;
      hi_a_in      = hi_a_ff;
      hi_b_in      = hi_b_ff;
      res_a_in     = res_a_ff;
      res_b_in     = res_b_ff;
      res_err_in   = res_err_ff;
      rsp_a_in     = rsp_a_ff;
      rsp_b_in     = rsp_b_ff;
      rsp_err_in   = rsp_err_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      mem_we       = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (act_ff == ACT_APPEND) begin
               if (!first_ff && (len_ff == LEN_FULL)) begin
                  res_a_in   = '0;
                  res_b_in   = '0;
                  res_err_in = 1'b1;
                  state_in   = S_RESULT;
               end else begin
                  if (first_ff) begin
                     len_in   = '0;
                     h_a_in   = '0;
                     h_b_in   = '0;
                     pow_a_in = A_W'(1);
                     pow_b_in = B_W'(1);
                  end
                  state_in = S_AP1;
               end
            end else begin
               if (q_bad) begin
                  res_a_in   = '0;
                  res_b_in   = '0;
                  res_err_in = 1'b1;
                  state_in   = S_RESULT;
               end else begin
                  state_in = S_Q1;
               end
            end
         end
         S_AP1: state_in = S_AP2;
         S_AP2: state_in = S_AP3;
         S_AP3: state_in = S_AP4;
         S_AP4: begin
            // new running hash out of the reducers
            h_a_in   = red_r_a;
            h_b_in   = red_r_b;
            state_in = S_AP5;
         end
         S_AP5: begin
            // next power ready: store both words, grow the string
            mem_we     = 1'b1;
            pow_a_in   = red_r_a;
            pow_b_in   = red_r_b;
            len_in     = len_ff + LEN_W'(1);
            res_a_in   = h_a_ff;
            res_b_in   = h_b_ff;
            res_err_in = 1'b0;
            state_in   = S_RESULT;
         end
         S_Q1: begin
            // pre[l-1] * 131^(r-l+1); zero when the substring starts at 0
            if (l_ff == '0) begin
               prod_a_in = '0;
               prod_b_in = '0;
            end else begin
               prod_a_in = (2 * A_W)'(prefix_rd_ff.a) * (2 * A_W)'(power_rd_ff.a);
               prod_b_in = (2 * B_W)'(prefix_rd_ff.b) * (2 * B_W)'(power_rd_ff.b);
            end
            state_in = S_Q2;
         end
         S_Q2: begin
            hi_a_in  = prefix_rd_ff.a;
            hi_b_in  = prefix_rd_ff.b;
            state_in = S_Q3;
         end
         S_Q3: state_in = S_Q4;
         S_Q4: state_in = S_Q5;
         S_Q5: state_in = S_Q6;
         S_Q6: begin
            res_a_in   = diff_a[A_W] ? diff_a[A_W-1:0] + MA : diff_a[A_W-1:0];
            res_b_in   = diff_b[B_W] ? diff_b[B_W-1:0] + MB : diff_b[B_W-1:0];
            res_err_in = 1'b0;
            state_in   = S_RESULT;
         end
         S_RESULT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_a_in     = res_a_ff;
               rsp_b_in     = res_b_ff;
               rsp_err_in   = res_err_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         len_ff       <= '0;
         h_a_ff       <= '0;
         h_b_ff       <= '0;
         pow_a_ff     <= A_W'(1);
         pow_b_ff     <= B_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         h_a_ff       <= h_a_in;
         h_b_ff       <= h_b_in;
         pow_a_ff     <= pow_a_in;
         pow_b_ff     <= pow_b_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         act_ff   <= req_tuser[REQ_USER_ACTION];
         first_ff <= req_tuser[REQ_USER_FIRST];
         byte_ff  <= req_tdata[BYTE_W-1:0];
         l_ff     <= req_tdata[BYTE_W+IDX_W-1:BYTE_W];
         r_ff     <= req_tdata[BYTE_W+2*IDX_W-1:BYTE_W+IDX_W];
      end
      prod_a_ff  <= prod_a_in;
      prod_b_ff  <= prod_b_in;
      hi_a_ff    <= hi_a_in;
      hi_b_ff    <= hi_b_in;
      res_a_ff   <= res_a_in;
      res_b_ff   <= res_b_in;
      res_err_ff <= res_err_in;
      rsp_a_ff   <= rsp_a_in;
      rsp_b_ff   <= rsp_b_in;
      rsp_err_ff <= rsp_err_in;
   end

   // Prefix and power memories; reads and writes never meet in one item
   always_ff @(posedge clock) begin
      if (mem_we) begin
         prefix_mem[pos_addr] <= '{b: h_b_ff, a: h_a_ff};
         power_mem[pos_addr]  <= '{b: red_r_b, a: red_r_a};
      end
      prefix_rd_ff <= prefix_mem[pre_raddr];
      power_rd_ff  <= power_mem[pow_raddr];
   end

   // Output packing
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_b_ff, rsp_a_ff});
   assign rsp_tuser  = RSP_USER_W'(rsp_err_ff);

endmodule
`default_nettype wire

### rtl/dmh_reduce.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dmh_reduce: pipelined Barrett reduction by a constant modulus
// Takes x < 2**(2*MOD_W) and returns x mod MODULUS through x_ff, q_ff, rem_ff and res_ff.
// MODULUS must lie in [2**(MOD_W-1), 2**MOD_W).
// ----------------------------------------------------------------------------
module dmh_reduce #(
   parameter int unsigned MODULUS = dmh_pkg::MOD_A,
   parameter int unsigned MOD_W   = dmh_pkg::A_W
) (
   input  wire logic                 clock,
   input  wire logic [2*MOD_W-1:0]   x,
   output logic      [MOD_W-1:0]     r
);
   localparam int unsigned XW = 2 * MOD_W;
   localparam logic [XW:0]      POW2    = {1'b1, {XW{1'b0}}};
   localparam logic [XW:0]      MU_FULL = POW2 / (XW + 1)'(MODULUS);
   localparam logic [MOD_W:0]   MU      = MU_FULL[MOD_W:0];
   localparam logic [MOD_W+1:0] M_EXT   = (MOD_W + 2)'(MODULUS);

   logic [XW-1:0]        x_ff;
   logic [MOD_W:0]       q_ff;
   logic [MOD_W:0]       q_in;
   logic [MOD_W+1:0]     xlo_ff;
   logic [MOD_W+1:0]     rem_ff;
   logic [MOD_W+1:0]     rem_in;
   logic [MOD_W+1:0]     fix1;
   logic [MOD_W+1:0]     fix2;
   logic [MOD_W-1:0]     res_ff;
   logic [2*MOD_W+1:0]   qest;
   logic [2*MOD_W+2:0]   qm;

   // Stage 1: quotient estimate from the top bits
   assign qest = {{(MOD_W + 1){1'b0}}, x_ff[XW-1:MOD_W-1]} * {{(MOD_W + 1){1'b0}}, MU};
   assign q_in = qest[2*MOD_W+1:MOD_W+1];

   // Stage 2: remainder estimate, below three moduli
   assign qm     = {{(MOD_W + 2){1'b0}}, q_ff} * {{(MOD_W + 1){1'b0}}, M_EXT};
   assign rem_in = xlo_ff - qm[MOD_W+1:0];

   // Stage 3: two conditional subtracts
   always_comb begin
      fix1 = (rem_ff >= M_EXT) ? rem_ff - M_EXT : rem_ff;
      fix2 = (fix1 >= M_EXT) ? fix1 - M_EXT : fix1;
   end

   always_ff @(posedge clock) begin
      x_ff   <= x;
      q_ff   <= q_in;
      xlo_ff <= x_ff[MOD_W+1:0];
      rem_ff <= rem_in;
      res_ff <= fix2[MOD_W-1:0];
   end

   assign r = res_ff;

endmodule
`default_nettype wire

### rtl/dmh_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dmh_checker: port-level checks for the string hash block
// Watches both streams of the top level; attached by the bind below.
// ----------------------------------------------------------------------------
module dmh_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_tvalid,
   input wire logic                              req_tready,
   input wire logic [dmh_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input wire logic [dmh_pkg::RSP_USER_W-1:0]    rsp_tuser,
   input wire logic                              rsp_tvalid,
   input wire logic                              rsp_tready
);
   import dmh_pkg::*;

   // One item at a time: no input taken right after an accepted one
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("dmh: input taken while an item is at work");

   // A stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("dmh: stalled result changed");

   // Refused items carry zero hashes
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> (rsp_tdata == '0))
      else $error("dmh: error result with nonzero hash");

   // Hashes are fully reduced
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tdata[A_W-1:0] < A_W'(MOD_A)) &&
                      (rsp_tdata[A_W+B_W-1:A_W] < B_W'(MOD_B))))
      else $error("dmh: hash not reduced");

endmodule

bind double_mod_prefix_string_hash dmh_checker u_dmh_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);
`default_nettype wire
